// ===== rtl/gsgtg_pkg.sv =====
package gsgtg_pkg;

	localparam int CORDIC_STEPS_DEF = 14;
	localparam int CORDIC_MAX = 20;

	localparam logic [1:0] CMD_POSE = 2'd0;
	localparam logic [1:0] CMD_MOVE = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;

	localparam logic [2:0] DIR_RIGHT = 3'd0;
	localparam logic [2:0] DIR_LEFT  = 3'd1;
	localparam logic [2:0] DIR_UP    = 3'd2;
	localparam logic [2:0] DIR_DOWN  = 3'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_POSE = 2'd1;
	localparam logic [1:0] ST_BUSY    = 2'd2;
	localparam logic [1:0] ST_BAD_DIR = 2'd3;

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_ROTATE = 2'd1;
	localparam logic [1:0] PH_MOVE   = 2'd2;

	localparam logic [2:0] REG_ANGLE_TOL = 3'd0;
	localparam logic [2:0] REG_DIST_TOL  = 3'd1;
	localparam logic [2:0] REG_ROT_GAIN  = 3'd2;
	localparam logic [2:0] REG_STEER     = 3'd3;
	localparam logic [2:0] REG_SPEED     = 3'd4;
	localparam logic [2:0] REG_MAX_ANG   = 3'd5;
	localparam logic [2:0] REG_MIN_LIN   = 3'd6;
	localparam logic [2:0] REG_MAX_LIN   = 3'd7;

	localparam logic signed [19:0] PI_Q13     = 20'sd25736;
	localparam logic signed [19:0] TWO_PI_Q13 = 20'sd51472;
	localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
	localparam logic signed [28:0] PI_Q24     = 29'sd52707179;
	localparam logic [15:0] INV_K_Q16 = 16'd39797;
	localparam logic signed [16:0] ONE_Q11 = 17'sd2048;

	typedef logic signed [36:0] cordic_t;
	typedef logic signed [28:0] angle24_t;

	function automatic angle24_t atan_q24(input logic [4:0] i);
		case (i)
			5'd0: atan_q24 = 29'sd13176795;
			5'd1: atan_q24 = 29'sd7778716;
			5'd2: atan_q24 = 29'sd4110060;
			5'd3: atan_q24 = 29'sd2086331;
			5'd4: atan_q24 = 29'sd1047214;
			5'd5: atan_q24 = 29'sd524117;
			5'd6: atan_q24 = 29'sd262123;
			5'd7: atan_q24 = 29'sd131069;
			5'd8: atan_q24 = 29'sd65536;
			5'd9: atan_q24 = 29'sd32768;
			5'd10: atan_q24 = 29'sd16384;
			5'd11: atan_q24 = 29'sd8192;
			5'd12: atan_q24 = 29'sd4096;
			5'd13: atan_q24 = 29'sd2048;
			5'd14: atan_q24 = 29'sd1024;
			5'd15: atan_q24 = 29'sd512;
			5'd16: atan_q24 = 29'sd256;
			5'd17: atan_q24 = 29'sd128;
			5'd18: atan_q24 = 29'sd64;
			5'd19: atan_q24 = 29'sd32;
			default: atan_q24 = 29'sd0;
		endcase
	endfunction

	// Angles here stay within one turn of the interval, so one correction suffices.
	function automatic logic signed [15:0] wrap_angle(input logic signed [19:0] e);
		logic signed [19:0] w;
		w = e;
		if (e > PI_Q13) begin
			w = e - TWO_PI_Q13;
		end else if (e <= -PI_Q13) begin
			w = e + TWO_PI_Q13;
		end
		wrap_angle = w[15:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
		if (v > 17'sd32767) begin
			sat16 = 16'sh7fff;
		end else if (v < -17'sd32768) begin
			sat16 = 16'sh8000;
		end else begin
			sat16 = v[15:0];
		end
	endfunction

endpackage

// ===== rtl/grid_step_go_to_goal_controller.sv =====
// Pose updates give no result; move commands give a status result. A rotating
// tick makes one pass through the shared multiplier for its gain, or none once aligned; a moving tick
// runs the CORDIC loop (at most CORDIC_MAX steps) and
// then up to three passes through one shared multiplier. One item is in work at a time.
// arst_n clears pose, phase, goal and grid state and loads register defaults.
module grid_step_go_to_goal_controller #(
	parameter int CORDIC_STEPS = gsgtg_pkg::CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         command,
	input  logic signed [15:0] pose_x,
	input  logic signed [15:0] pose_y,
	input  logic signed [15:0] pose_heading,
	input  logic [2:0]         move_dir,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               result_kind,
	output logic [14:0]        linear_vel,
	output logic signed [15:0] angular_vel,
	output logic [1:0]         cmd_status,
	output logic [1:0]         motion_phase,
	output logic signed [15:0] grid_x,
	output logic signed [15:0] grid_y,
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam int NSTEPS = (CORDIC_STEPS < gsgtg_pkg::CORDIC_MAX) ?
		CORDIC_STEPS : gsgtg_pkg::CORDIC_MAX;
	localparam logic [4:0] LAST_STEP = 5'(NSTEPS - 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CORD = 3'd1;
	localparam logic [2:0] S_DMUL = 3'd2;
	localparam logic [2:0] S_DIST = 3'd3;
	localparam logic [2:0] S_SPD  = 3'd4;
	localparam logic [2:0] S_GMUL = 3'd5;
	localparam logic [2:0] S_GAIN = 3'd6;
	localparam logic [2:0] S_OUT  = 3'd7;

	logic [2:0] state_q;
	logic [4:0] iter_q;

	logic [12:0] ang_tol_q, dist_tol_q;
	logic [15:0] rot_gain_q, steer_gain_q, speed_gain_q;
	logic [14:0] max_ang_q, min_lin_q, max_lin_q;

	logic pose_known_q;
	logic [1:0] phase_q;
	logic signed [15:0] cur_x_q, cur_y_q, cur_hd_q, goal_x_q, goal_y_q, goal_hd_q;
	logic signed [15:0] lx_q, ly_q;

	gsgtg_pkg::cordic_t x_q, y_q;
	gsgtg_pkg::angle24_t z_q;
	logic [19:0] dist_q;
	logic signed [15:0] err_q;
	logic [14:0] lin_q;
	logic signed [15:0] ang_q;
	logic kind_q;
	logic [1:0] status_q;
	logic [51:0] prod_q;

	logic out_valid_q;
	logic out_kind_q;
	logic [14:0] out_lin_q;
	logic signed [15:0] out_ang_q;
	logic [1:0] out_status_q, out_phase_q;
	logic signed [15:0] out_gx_q, out_gy_q;

	logic accept, out_free;
	logic [35:0] mul_a;
	logic [15:0] mul_b;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || !out_free;
	assign accept = in_valid && !in_stall;

	// Shared multiplier operand selection.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_DMUL: begin
				mul_a = x_q[36] ? 36'd0 : x_q[35:0];
				mul_b = gsgtg_pkg::INV_K_Q16;
			end
			S_SPD: begin
				mul_a = {16'd0, dist_q};
				mul_b = speed_gain_q;
			end
			S_GMUL: begin
				mul_a = {20'd0, (err_q < 0) ? 16'(-err_q) : err_q};
				mul_b = (phase_q == gsgtg_pkg::PH_ROTATE) ? rot_gain_q : steer_gain_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	logic signed [16:0] dx, dy;
	logic signed [19:0] hd_err_raw;
	logic signed [15:0] hd_err;
	logic [15:0] hd_mag;
	logic signed [36:0] xs, ys;
	logic [28:0] z_mag;
	logic [17:0] bmag;
	logic signed [19:0] bearing;
	logic signed [15:0] br_err;
	logic [52:0] dist_sum;
	logic [36:0] v_sum;
	logic [26:0] v_raw, v_lo;
	logic [32:0] g_sum;
	logic [20:0] g_raw;
	logic [14:0] g_lim;
	logic signed [16:0] gx_p, gx_m, gy_p, gy_m;

	always_comb begin
		dx = 17'(goal_x_q) - 17'(cur_x_q);
		dy = 17'(goal_y_q) - 17'(cur_y_q);
		hd_err_raw = 20'(goal_hd_q) - 20'(cur_hd_q);
		hd_err = gsgtg_pkg::wrap_angle(hd_err_raw);
		hd_mag = (hd_err < 0) ? 16'(-hd_err) : hd_err;
		xs = x_q >>> iter_q;
		ys = y_q >>> iter_q;
		z_mag = (z_q < 0) ? 29'(-z_q) : z_q;
		bmag = 18'((30'(z_mag) + 30'd1024) >> 11);
		bearing = (z_q < 0) ? -20'(bmag) : 20'(bmag);
		br_err = gsgtg_pkg::wrap_angle(bearing - 20'(cur_hd_q));
		dist_sum = 53'(prod_q) + 53'h0_0000_8000_0000;
		v_sum = 37'(prod_q) + 37'd512;
		v_raw = v_sum[36:10];
		v_lo = (v_raw < 27'(min_lin_q)) ? 27'(min_lin_q) : v_raw;
		g_sum = 33'(prod_q) + 33'd2048;
		g_raw = g_sum[32:12];
		g_lim = (g_raw > 21'(max_ang_q)) ? max_ang_q : g_raw[14:0];
		gx_p = 17'(cur_x_q) + gsgtg_pkg::ONE_Q11;
		gx_m = 17'(cur_x_q) - gsgtg_pkg::ONE_Q11;
		gy_p = 17'(cur_y_q) + gsgtg_pkg::ONE_Q11;
		gy_m = 17'(cur_y_q) - gsgtg_pkg::ONE_Q11;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ang_tol_q <= 13'd246;
			dist_tol_q <= 13'd61;
			rot_gain_q <= 16'd8192;
			steer_gain_q <= 16'd16384;
			speed_gain_q <= 16'd6144;
			max_ang_q <= 15'd12288;
			min_lin_q <= 15'd1229;
			max_lin_q <= 15'd8192;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				gsgtg_pkg::REG_ANGLE_TOL: ang_tol_q <= cfg_data[12:0];
				gsgtg_pkg::REG_DIST_TOL:  dist_tol_q <= cfg_data[12:0];
				gsgtg_pkg::REG_ROT_GAIN:  rot_gain_q <= cfg_data;
				gsgtg_pkg::REG_STEER:     steer_gain_q <= cfg_data;
				gsgtg_pkg::REG_SPEED:     speed_gain_q <= cfg_data;
				gsgtg_pkg::REG_MAX_ANG:   max_ang_q <= cfg_data[14:0];
				gsgtg_pkg::REG_MIN_LIN:   min_lin_q <= cfg_data[14:0];
				gsgtg_pkg::REG_MAX_LIN:   max_lin_q <= cfg_data[14:0];
				default: ang_tol_q <= ang_tol_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			iter_q <= '0;
			pose_known_q <= 1'b0;
			phase_q <= gsgtg_pkg::PH_IDLE;
			cur_x_q <= '0;
			cur_y_q <= '0;
			cur_hd_q <= '0;
			goal_x_q <= '0;
			goal_y_q <= '0;
			goal_hd_q <= '0;
			lx_q <= '0;
			ly_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						lin_q <= '0;
						ang_q <= '0;
						kind_q <= 1'b0;
						status_q <= gsgtg_pkg::ST_OK;
						case (command)
							gsgtg_pkg::CMD_POSE: begin
								cur_x_q <= pose_x;
								cur_y_q <= pose_y;
								cur_hd_q <= pose_heading;
								pose_known_q <= 1'b1;
							end
							gsgtg_pkg::CMD_MOVE: begin
								kind_q <= 1'b1;
								state_q <= S_OUT;
								if (!pose_known_q) begin
									status_q <= gsgtg_pkg::ST_NO_POSE;
								end else if (phase_q != gsgtg_pkg::PH_IDLE) begin
									status_q <= gsgtg_pkg::ST_BUSY;
								end else if (move_dir > gsgtg_pkg::DIR_DOWN) begin
									status_q <= gsgtg_pkg::ST_BAD_DIR;
								end else begin
									phase_q <= gsgtg_pkg::PH_ROTATE;
									goal_x_q <= cur_x_q;
									goal_y_q <= cur_y_q;
									case (move_dir)
										gsgtg_pkg::DIR_RIGHT: begin
											lx_q <= lx_q + 16'sd1;
											goal_x_q <= gsgtg_pkg::sat16(gx_p);
											goal_hd_q <= '0;
										end
										gsgtg_pkg::DIR_LEFT: begin
											lx_q <= lx_q - 16'sd1;
											goal_x_q <= gsgtg_pkg::sat16(gx_m);
											goal_hd_q <= 16'(gsgtg_pkg::PI_Q13);
										end
										gsgtg_pkg::DIR_UP: begin
											ly_q <= ly_q + 16'sd1;
											goal_y_q <= gsgtg_pkg::sat16(gy_p);
											goal_hd_q <= gsgtg_pkg::HALF_PI_Q13;
										end
										default: begin
											ly_q <= ly_q - 16'sd1;
											goal_y_q <= gsgtg_pkg::sat16(gy_m);
											goal_hd_q <= -gsgtg_pkg::HALF_PI_Q13;
										end
									endcase
								end
							end
							gsgtg_pkg::CMD_TICK: begin
								if (pose_known_q && phase_q == gsgtg_pkg::PH_ROTATE) begin
									if (hd_mag > 16'(ang_tol_q)) begin
										err_q <= hd_err;
										state_q <= S_GMUL;
									end else begin
										phase_q <= gsgtg_pkg::PH_MOVE;
										state_q <= S_OUT;
									end
								end else if (pose_known_q && phase_q == gsgtg_pkg::PH_MOVE) begin
									// Start in the right half plane; a left vector is negated
									// and the angle starts at pi.
									if (dx < 0) begin
										x_q <= -(37'(dx) <<< 16);
										y_q <= -(37'(dy) <<< 16);
										z_q <= gsgtg_pkg::PI_Q24;
									end else begin
										x_q <= 37'(dx) <<< 16;
										y_q <= 37'(dy) <<< 16;
										z_q <= '0;
									end
									iter_q <= '0;
									state_q <= S_CORD;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_CORD: begin
					if (y_q > 0) begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + gsgtg_pkg::atan_q24(iter_q);
					end else begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - gsgtg_pkg::atan_q24(iter_q);
					end
					iter_q <= iter_q + 5'd1;
					if (iter_q == LAST_STEP) begin
						state_q <= S_DMUL;
					end
				end
				S_DMUL: begin
					state_q <= S_DIST;
				end
				S_DIST: begin
					dist_q <= dist_sum[51:32];
					if (dist_sum[52:32] > 21'(dist_tol_q)) begin
						err_q <= br_err;
						state_q <= S_SPD;
					end else begin
						phase_q <= gsgtg_pkg::PH_IDLE;
						state_q <= S_OUT;
					end
				end
				S_SPD: begin
					// The speed product formed here is read in S_GMUL.
					state_q <= S_GMUL;
				end
				S_GMUL: begin
					if (phase_q == gsgtg_pkg::PH_MOVE) begin
						lin_q <= (v_lo > 27'(max_lin_q)) ? max_lin_q : v_lo[14:0];
					end
					state_q <= S_GAIN;
				end
				S_GAIN: begin
					ang_q <= (err_q < 0) ? -16'(g_lim) : 16'(g_lim);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_kind_q <= kind_q;
						out_lin_q <= lin_q;
						out_ang_q <= ang_q;
						out_status_q <= status_q;
						out_phase_q <= phase_q;
						out_gx_q <= lx_q;
						out_gy_q <= ly_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign result_kind = out_kind_q;
	assign linear_vel = out_lin_q;
	assign angular_vel = out_ang_q;
	assign cmd_status = out_status_q;
	assign motion_phase = out_phase_q;
	assign grid_x = out_gx_q;
	assign grid_y = out_gy_q;

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> in_stall)
		else $error("input taken while a request is in work");

	a_cordic_moving: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CORD |-> phase_q == gsgtg_pkg::PH_MOVE && iter_q <= LAST_STEP)
		else $error("CORDIC running outside the moving phase or past its last step");

	a_out_phase: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> out_phase_q != 2'd3 &&
		(out_kind_q || out_status_q == gsgtg_pkg::ST_OK))
		else $error("bad result fields");

endmodule

// ===== test/tb_grid_step_go_to_goal_controller.sv =====
`timescale 1ns / 1ps

module tb_grid_step_go_to_goal_controller;

	typedef struct packed {
		logic               kind;
		logic [14:0]        lin;
		logic signed [15:0] ang;
		logic [1:0]         status;
		logic [1:0]         phase;
		logic signed [15:0] gx;
		logic signed [15:0] gy;
	} ctrl_result_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [15:0] ph;
		logic [2:0]         dir;
		logic               typed;
		ctrl_result_t       want;
	} request_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         command;
	logic signed [15:0] pose_x;
	logic signed [15:0] pose_y;
	logic signed [15:0] pose_heading;
	logic [2:0]         move_dir;
	logic               out_valid;
	logic               out_stall;
	logic               result_kind;
	logic [14:0]        linear_vel;
	logic signed [15:0] angular_vel;
	logic [1:0]         cmd_status;
	logic [1:0]         motion_phase;
	logic signed [15:0] grid_x;
	logic signed [15:0] grid_y;
	logic               cfg_wr_en;
	logic [2:0]         cfg_index;
	logic [15:0]        cfg_data;

	grid_step_go_to_goal_controller DUT (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.command(command), .pose_x(pose_x), .pose_y(pose_y),
		.pose_heading(pose_heading), .move_dir(move_dir), .out_valid(out_valid),
		.out_stall(out_stall), .result_kind(result_kind), .linear_vel(linear_vel),
		.angular_vel(angular_vel), .cmd_status(cmd_status),
		.motion_phase(motion_phase), .grid_x(grid_x), .grid_y(grid_y),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Controller state as the checker sees it.
	logic [15:0]        ang_tol, dist_tol, rot_gain, steer_gain, speed_gain;
	logic [15:0]        max_ang, min_lin, max_lin;
	logic               pose_known;
	logic [1:0]         ctl_phase;
	int                 cur_x, cur_y, cur_h, goal_x, goal_y, goal_h;
	logic [15:0]        logical_x, logical_y;

	ctrl_result_t       pending_results[$];
	int                 mismatches;
	int                 idle_cycles;
	int                 burst_left;
	int                 stall_mode;
	int                 stall_cycle;
	int                 sent;

	longint             atan_tbl[20] = '{
		13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32
	};

	always #5 clk = ~clk;

	function automatic int wrap_err(int e);
		while (e > 25736) e -= 51472;
		while (e <= -25736) e += 51472;
		return e;
	endfunction

	function automatic int gain_clamp(longint gain, int e, longint lim);
		longint m;
		longint r;
		m = (e < 0) ? -e : e;
		r = (gain * m + 2048) >>> 12;
		if (r > lim) r = lim;
		return (e < 0) ? -int'(r) : int'(r);
	endfunction

	function automatic int clamp16(int v);
		return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
	endfunction

	// Vectoring CORDIC giving range in unsigned Q6.11 and bearing in Q3.13.
	task automatic range_bearing(input int dx, input int dy, output longint range_q11,
			output int bearing);
		longint x, y, z, nx, ny, ux, m;
		x = longint'(dx) * 65536;
		y = longint'(dy) * 65536;
		z = 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 52707179;
		end
		for (int i = 0; i < gsgtg_pkg::CORDIC_STEPS_DEF && i < 20; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z += atan_tbl[i];
			end else begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z -= atan_tbl[i];
			end
			x = nx;
			y = ny;
		end
		ux = (x < 0) ? 0 : x;
		range_q11 = (ux * 39797 + (64'sd1 <<< 31)) >>> 32;
		m = (z < 0) ? -z : z;
		m = (m + 1024) >>> 11;
		bearing = (z < 0) ? -int'(m) : int'(m);
	endtask

	task automatic predict_step(input request_t r, output bit has, output ctrl_result_t res);
		longint range_q11, v;
		int     bearing, e, mag;
		res = '0;
		has = 1'b1;
		case (r.cmd)
			gsgtg_pkg::CMD_POSE: begin
				cur_x = r.px;
				cur_y = r.py;
				cur_h = r.ph;
				pose_known = 1'b1;
				has = 1'b0;
			end
			gsgtg_pkg::CMD_MOVE: begin
				res.kind = 1'b1;
				if (!pose_known) begin
					res.status = gsgtg_pkg::ST_NO_POSE;
				end else if (ctl_phase != gsgtg_pkg::PH_IDLE) begin
					res.status = gsgtg_pkg::ST_BUSY;
				end else if (r.dir > gsgtg_pkg::DIR_DOWN) begin
					res.status = gsgtg_pkg::ST_BAD_DIR;
				end else begin
					goal_x = cur_x;
					goal_y = cur_y;
					case (r.dir)
						gsgtg_pkg::DIR_RIGHT: begin
							logical_x++;
							goal_x = clamp16(cur_x + 2048);
							goal_h = 0;
						end
						gsgtg_pkg::DIR_LEFT: begin
							logical_x--;
							goal_x = clamp16(cur_x - 2048);
							goal_h = 25736;
						end
						gsgtg_pkg::DIR_UP: begin
							logical_y++;
							goal_y = clamp16(cur_y + 2048);
							goal_h = 12868;
						end
						default: begin
							logical_y--;
							goal_y = clamp16(cur_y - 2048);
							goal_h = -12868;
						end
					endcase
					ctl_phase = gsgtg_pkg::PH_ROTATE;
				end
			end
			gsgtg_pkg::CMD_TICK: begin
				if (!pose_known || ctl_phase == gsgtg_pkg::PH_IDLE) begin
					has = 1'b0;
				end else if (ctl_phase == gsgtg_pkg::PH_ROTATE) begin
					e = wrap_err(goal_h - cur_h);
					mag = (e < 0) ? -e : e;
					if (mag > ang_tol) res.ang = 16'(gain_clamp(rot_gain, e, max_ang));
					else ctl_phase = gsgtg_pkg::PH_MOVE;
				end else begin
					range_bearing(goal_x - cur_x, goal_y - cur_y, range_q11, bearing);
					if (range_q11 > dist_tol) begin
						e = wrap_err(bearing - cur_h);
						v = (longint'(speed_gain) * range_q11 + 512) >>> 10;
						if (v < min_lin) v = min_lin;
						if (v > max_lin) v = max_lin;
						res.lin = v[14:0];
						res.ang = 16'(gain_clamp(steer_gain, e, max_ang));
					end else begin
						ctl_phase = gsgtg_pkg::PH_IDLE;
					end
				end
			end
			default: has = 1'b0;
		endcase
		res.phase = ctl_phase;
		res.gx = logical_x;
		res.gy = logical_y;
	endtask

	// Presents one request, waits for acceptance, then records the expected result.
	task automatic issue(input request_t r);
		bit           has;
		ctrl_result_t res;
		if (burst_left == 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end else begin
			@(negedge clk);
		end
		burst_left--;
		command = r.cmd;
		pose_x = r.px;
		pose_y = r.py;
		pose_heading = r.ph;
		move_dir = r.dir;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		sent++;
		predict_step(r, has, res);
		if (has) pending_results.push_back(r.typed ? r.want : res);
	endtask

	function automatic request_t req(logic [1:0] c, int x, int y, int h, logic [2:0] d);
		request_t r;
		r = '0;
		r.cmd = c;
		r.px = x;
		r.py = y;
		r.ph = h;
		r.dir = d;
		return r;
	endfunction

	function automatic request_t typed_req(request_t r, logic kind, logic [1:0] st,
			logic [1:0] ph, int gx, int gy);
		r.typed = 1'b1;
		r.want = '0;
		r.want.kind = kind;
		r.want.status = st;
		r.want.phase = ph;
		r.want.gx = gx;
		r.want.gy = gy;
		return r;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		case (idx)
			gsgtg_pkg::REG_ANGLE_TOL: ang_tol = val & 16'h1fff;
			gsgtg_pkg::REG_DIST_TOL:  dist_tol = val & 16'h1fff;
			gsgtg_pkg::REG_ROT_GAIN:  rot_gain = val;
			gsgtg_pkg::REG_STEER:     steer_gain = val;
			gsgtg_pkg::REG_SPEED:     speed_gain = val;
			gsgtg_pkg::REG_MAX_ANG:   max_ang = val & 16'h7fff;
			gsgtg_pkg::REG_MIN_LIN:   min_lin = val & 16'h7fff;
			default:                  max_lin = val & 16'h7fff;
		endcase
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	function automatic int near(int center, int span);
		return clamp16(center + $signed($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic int near_heading(int center, int span);
		int h;
		h = center + $signed($urandom_range(0, 2 * span)) - span;
		return (h > 25736) ? 25736 : ((h < -25736) ? -25736 : h);
	endfunction

	// One full grid step: start pose, move, then ticks mixed with poses closing in on the goal and stray commands.
	task automatic grid_step_sequence();
		int       n;
		int       span;
		int       sx, sy;
		request_t r;
		if ($urandom_range(0, 7) == 0) begin
			sx = $signed(16'($urandom));
			sy = $signed(16'($urandom));
		end else begin
			sx = $signed($urandom_range(0, 16000)) - 8000;
			sy = $signed($urandom_range(0, 16000)) - 8000;
		end
		issue(req(gsgtg_pkg::CMD_POSE, sx, sy, near_heading(0, 25736), 3'd0));
		issue(req(gsgtg_pkg::CMD_MOVE, 0, 0, 0,
			($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3))));
		n = 0;
		while (ctl_phase != gsgtg_pkg::PH_IDLE) begin
			span = (n < 24) ? (4096 >> (n / 3)) : 0;
			case ($urandom_range(0, 19))
				0: issue(req(gsgtg_pkg::CMD_MOVE, 0, 0, 0, 3'($urandom)));
				1: issue(req(2'd3, $urandom, $urandom, $urandom, 3'($urandom)));
				2, 3, 4, 5, 6, 7: begin
					if (span == 0)
						r = req(gsgtg_pkg::CMD_POSE, goal_x, goal_y, goal_h, 3'($urandom));
					else
						r = req(gsgtg_pkg::CMD_POSE, near(goal_x, span), near(goal_y, span),
							near_heading(goal_h, 2 * span), 3'($urandom));
					issue(r);
				end
				default: issue(req(gsgtg_pkg::CMD_TICK, $urandom, $urandom, $urandom,
					3'($urandom)));
			endcase
			n++;
		end
		if ($urandom_range(0, 3) == 0) issue(req(gsgtg_pkg::CMD_TICK, 0, 0, 0, 3'd0));
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %s: expected %0d, got %0d", name, want, got);
		end
	endtask

	always @(posedge clk) begin
		ctrl_result_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("mismatch: result with none expected");
			end else begin
				w = pending_results.pop_front();
				check_field("result_kind", w.kind, result_kind);
				check_field("linear_vel", w.lin, linear_vel);
				check_field("angular_vel", w.ang, angular_vel);
				check_field("cmd_status", w.status, cmd_status);
				check_field("motion_phase", w.phase, motion_phase);
				check_field("grid_x", w.gx, grid_x);
				check_field("grid_y", w.gy, grid_y);
			end
		end
	end

	// Receiver backpressure follows one of four patterns, picked anew at random.
	always @(negedge clk) begin
		stall_cycle++;
		if (stall_cycle % 100 == 0) stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 2) == 0);
			2: out_stall <= (stall_cycle % 5 < 3);
			default: out_stall <= ($urandom_range(0, 9) < 8);
		endcase
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= 5000) begin
			$display("[grid_step_go_to_goal_controller] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		request_t directed[$];
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		command = gsgtg_pkg::CMD_POSE;
		pose_x = '0;
		pose_y = '0;
		pose_heading = '0;
		move_dir = gsgtg_pkg::DIR_RIGHT;
		cfg_wr_en = 1'b0;
		cfg_index = gsgtg_pkg::REG_ANGLE_TOL;
		cfg_data = '0;
		mismatches = 0;
		idle_cycles = 0;
		burst_left = 0;
		stall_mode = 0;
		stall_cycle = 0;
		sent = 0;
		ang_tol = 246; dist_tol = 61; rot_gain = 8192; steer_gain = 16384;
		speed_gain = 6144; max_ang = 12288; min_lin = 1229; max_lin = 8192;
		pose_known = 1'b0;
		ctl_phase = gsgtg_pkg::PH_IDLE;
		cur_x = 0; cur_y = 0; cur_h = 0; goal_x = 0; goal_y = 0; goal_h = 0;
		logical_x = '0; logical_y = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Register defaults; edge poses make the goal saturate.
		directed.push_back(req(gsgtg_pkg::CMD_TICK, 0, 0, 0, gsgtg_pkg::DIR_RIGHT));
		directed.push_back(typed_req(req(gsgtg_pkg::CMD_MOVE, 0, 0, 0, gsgtg_pkg::DIR_RIGHT),
			1, gsgtg_pkg::ST_NO_POSE, gsgtg_pkg::PH_IDLE, 0, 0));
		directed.push_back(req(2'd3, -1, -1, -1, 3'd7));
		directed.push_back(req(gsgtg_pkg::CMD_POSE, 32767, -32768, 25736, gsgtg_pkg::DIR_RIGHT));
		directed.push_back(typed_req(req(gsgtg_pkg::CMD_MOVE, 0, 0, 0, 3'd7),
			1, gsgtg_pkg::ST_BAD_DIR, gsgtg_pkg::PH_IDLE, 0, 0));
		directed.push_back(typed_req(req(gsgtg_pkg::CMD_MOVE, 0, 0, 0, 3'd4),
			1, gsgtg_pkg::ST_BAD_DIR, gsgtg_pkg::PH_IDLE, 0, 0));
		directed.push_back(typed_req(req(gsgtg_pkg::CMD_MOVE, 0, 0, 0, gsgtg_pkg::DIR_RIGHT),
			1, gsgtg_pkg::ST_OK, gsgtg_pkg::PH_ROTATE, 1, 0));
		directed.push_back(typed_req(req(gsgtg_pkg::CMD_MOVE, 0, 0, 0, gsgtg_pkg::DIR_UP),
			1, gsgtg_pkg::ST_BUSY, gsgtg_pkg::PH_ROTATE, 1, 0));
		directed.push_back(req(gsgtg_pkg::CMD_TICK, 0, 0, 0, gsgtg_pkg::DIR_RIGHT));
		directed.push_back(req(gsgtg_pkg::CMD_POSE, 32767, -32768, 0, gsgtg_pkg::DIR_RIGHT));
		directed.push_back(typed_req(req(gsgtg_pkg::CMD_TICK, 0, 0, 0, gsgtg_pkg::DIR_RIGHT),
			0, gsgtg_pkg::ST_OK, gsgtg_pkg::PH_MOVE, 1, 0));
		directed.push_back(typed_req(req(gsgtg_pkg::CMD_TICK, 0, 0, 0, gsgtg_pkg::DIR_RIGHT),
			0, gsgtg_pkg::ST_OK, gsgtg_pkg::PH_IDLE, 1, 0));
		directed.push_back(req(gsgtg_pkg::CMD_POSE, -32768, 32767, -25736, gsgtg_pkg::DIR_RIGHT));
		directed.push_back(typed_req(req(gsgtg_pkg::CMD_MOVE, 0, 0, 0, gsgtg_pkg::DIR_LEFT),
			1, gsgtg_pkg::ST_OK, gsgtg_pkg::PH_ROTATE, 0, 0));
		// A heading of -pi already matches a goal heading of pi.
		directed.push_back(typed_req(req(gsgtg_pkg::CMD_TICK, 0, 0, 0, gsgtg_pkg::DIR_RIGHT),
			0, gsgtg_pkg::ST_OK, gsgtg_pkg::PH_MOVE, 0, 0));
		directed.push_back(req(gsgtg_pkg::CMD_POSE, -32768, 32767, 25736, gsgtg_pkg::DIR_RIGHT));
		directed.push_back(typed_req(req(gsgtg_pkg::CMD_TICK, 0, 0, 0, gsgtg_pkg::DIR_RIGHT),
			0, gsgtg_pkg::ST_OK, gsgtg_pkg::PH_IDLE, 0, 0));
		directed.push_back(req(gsgtg_pkg::CMD_TICK, 0, 0, 0, gsgtg_pkg::DIR_RIGHT));
		directed.push_back(req(gsgtg_pkg::CMD_POSE, 0, 0, -25736, gsgtg_pkg::DIR_RIGHT));
		directed.push_back(typed_req(req(gsgtg_pkg::CMD_MOVE, 0, 0, 0, gsgtg_pkg::DIR_UP),
			1, gsgtg_pkg::ST_OK, gsgtg_pkg::PH_ROTATE, 0, 1));
		directed.push_back(req(gsgtg_pkg::CMD_TICK, 0, 0, 0, gsgtg_pkg::DIR_RIGHT));
		directed.push_back(req(gsgtg_pkg::CMD_POSE, 1000, -500, 12868, gsgtg_pkg::DIR_RIGHT));
		directed.push_back(typed_req(req(gsgtg_pkg::CMD_TICK, 0, 0, 0, gsgtg_pkg::DIR_RIGHT),
			0, gsgtg_pkg::ST_OK, gsgtg_pkg::PH_MOVE, 0, 1));
		directed.push_back(req(gsgtg_pkg::CMD_TICK, 0, 0, 0, gsgtg_pkg::DIR_RIGHT));
		directed.push_back(req(gsgtg_pkg::CMD_POSE, 0, 2048, 12868, gsgtg_pkg::DIR_RIGHT));
		directed.push_back(typed_req(req(gsgtg_pkg::CMD_TICK, 0, 0, 0, gsgtg_pkg::DIR_RIGHT),
			0, gsgtg_pkg::ST_OK, gsgtg_pkg::PH_IDLE, 0, 1));
		foreach (directed[i]) issue(directed[i]);

		for (int setting = 0; setting < 6; setting++) begin
			drain();
			for (int idx = 0; idx < 8; idx++) begin
				case (setting)
					1: write_reg(3'(idx), 16'h0000);
					2: write_reg(3'(idx), 16'hffff);
					3: write_reg(3'(idx), (3'(idx) == gsgtg_pkg::REG_MIN_LIN) ? 16'h7fff :
						(3'(idx) == gsgtg_pkg::REG_MAX_LIN) ? 16'd900 : 16'($urandom));
					default: write_reg(3'(idx), 16'($urandom));
				endcase
			end
			while (sent < directed.size() + (setting + 1) * 165) begin
				grid_step_sequence();
			end
		end

		drain();
		if (mismatches == 0) begin
			$display("[grid_step_go_to_goal_controller] OK");
		end else begin
			$display("[grid_step_go_to_goal_controller] ERROR");
		end
		$finish;
	end

endmodule
